@@ hdl/lrup_pkg.sv @@
`timescale 1ns / 1ps

package lrup_pkg;

    // Width of the frames_in_use configuration register.
    localparam int CFG_W = 5;

    // Value of frames_in_use after reset.
    localparam logic [CFG_W-1:0] CFG_RESET_VAL = 5'd16;

    // Widths of the result fields.
    localparam int FRAME_IDX_W = 4;
    localparam int FAULT_CNT_W = 32;

    // Sequencer states of the replacement controller.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_UPD,
        S_DONE
    } t_state;

endpackage

@@ hdl/lrup_if.sv @@
`timescale 1ns / 1ps

// Request channel: one page reference per transfer.
interface lrup_req_if
    import lrup_pkg::*;
#(
    parameter int PAGE_BITS = 16
) ();
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page;
    logic                 first_of_sequence;

    modport source (output valid, output page, output first_of_sequence, input ready);
    modport sink   (input valid, input page, input first_of_sequence, output ready);
endinterface

// Response channel: one result per reference.
interface lrup_rsp_if
    import lrup_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   fault;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic [FAULT_CNT_W-1:0] fault_count;

    modport source (output valid, output fault, output frame_index, output fault_count,
                    input ready);
    modport sink   (input valid, input fault, input frame_index, input fault_count,
                    output ready);
endinterface

@@ hdl/lrup_frame_mem.sv @@
`timescale 1ns / 1ps

module lrup_frame_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 20,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/lrup_ctrl.sv @@
`timescale 1ns / 1ps

module lrup_ctrl
    import lrup_pkg::*;
#(
    parameter int FRAME_COUNT = 16,
    parameter int PAGE_BITS   = 16,
    localparam int IW         = $clog2(FRAME_COUNT),
    localparam int CNT_W      = $clog2(FRAME_COUNT + 1),
    localparam int MW         = PAGE_BITS + IW
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_active,
    lrup_req_if.sink         i_req,
    lrup_rsp_if.source       o_rsp,
    output logic             o_mem_rd_en,
    output logic [IW-1:0]    o_mem_rd_addr,
    input  logic [MW-1:0]    i_mem_rd_data,
    output logic             o_mem_wr_en,
    output logic [IW-1:0]    o_mem_wr_addr,
    output logic [MW-1:0]    o_mem_wr_data
);

    t_state r_state;
    t_state n_state;

    logic [FRAME_COUNT-1:0] r_valid;
    logic [FAULT_CNT_W-1:0] r_fault_cnt;
    logic [PAGE_BITS-1:0]   r_page;

    // Pass counters: read issue index and index of the data returning.
    logic [CNT_W-1:0] r_rd_idx;
    logic             r_chk_vld;
    logic [IW-1:0]    r_chk_idx;

    // Scan results.
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [IW-1:0] r_hit_rank;
    logic          r_empty;
    logic [IW-1:0] r_empty_idx;
    logic [IW-1:0] r_worst_idx;
    logic [IW-1:0] r_worst_rank;

    // Chosen frame for the recency update.
    logic [IW-1:0] r_sel_idx;
    logic          r_sel_prev_valid;
    logic [IW-1:0] r_sel_rank;
    logic          r_fault;

    // Output register.
    logic                   r_out_vld;
    logic                   r_out_fault;
    logic [FRAME_IDX_W-1:0] r_out_idx;
    logic [FAULT_CNT_W-1:0] r_out_cnt;

    logic                 req_xfer;
    logic                 out_free;
    logic [CNT_W-1:0]     active_last;
    logic                 scan_last;
    logic                 upd_last;
    logic [PAGE_BITS-1:0] rd_page;
    logic [IW-1:0]        rd_rank;
    logic                 rd_frame_valid;
    logic                 pick_fault;
    logic [IW-1:0]        pick_idx;
    logic                 pick_prev_valid;
    logic [IW-1:0]        pick_rank;

    assign req_xfer       = i_req.valid && i_req.ready;
    assign out_free       = !r_out_vld || o_rsp.ready;
    assign active_last    = i_active - CNT_W'(1);
    assign scan_last      = r_chk_vld && (r_chk_idx == active_last[IW-1:0]);
    assign upd_last       = r_chk_vld && (r_chk_idx == IW'(FRAME_COUNT - 1));
    assign rd_page        = i_mem_rd_data[MW-1:IW];
    assign rd_rank        = i_mem_rd_data[IW-1:0];
    assign rd_frame_valid = r_valid[r_chk_idx];

    // Frame choice: hit frame, else first empty frame, else least recent.
    assign pick_fault      = !r_hit;
    assign pick_idx        = r_hit ? r_hit_idx : (r_empty ? r_empty_idx : r_worst_idx);
    assign pick_prev_valid = r_hit || !r_empty;
    assign pick_rank       = r_hit ? r_hit_rank : r_worst_rank;

    // Handshake outputs.
    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.fault       = r_out_fault;
    assign o_rsp.frame_index = r_out_idx;
    assign o_rsp.fault_count = r_out_cnt;

    // Next state and frame table accesses.
    always_comb begin
        n_state       = r_state;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_rd_idx[IW-1:0];
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_chk_idx;
        o_mem_wr_data = {rd_page, rd_rank + IW'(1)};
        case (r_state)
            S_IDLE: begin
                if (req_xfer) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_mem_rd_en = (r_rd_idx < i_active);
                if (scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                o_mem_rd_en = (r_rd_idx < CNT_W'(FRAME_COUNT));
                if (r_chk_vld) begin
                    if (r_chk_idx == r_sel_idx) begin
                        o_mem_wr_en   = 1'b1;
                        o_mem_wr_data = {r_page, IW'(0)};
                    end else if (rd_frame_valid &&
                                 (!r_sel_prev_valid || (rd_rank < r_sel_rank))) begin
                        o_mem_wr_en = 1'b1;
                    end
                end
                if (upd_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pass counters for the scan and update sweeps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_vld <= 1'b0;
            r_rd_idx  <= '0;
        end else if (req_xfer || (r_state == S_PICK)) begin
            r_chk_vld <= 1'b0;
            r_rd_idx  <= '0;
        end else if ((r_state == S_SCAN) || (r_state == S_UPD)) begin
            r_chk_vld <= o_mem_rd_en;
            r_chk_idx <= r_rd_idx[IW-1:0];
            if (o_mem_rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
        end
    end

    // Associative match, first empty frame and least recent frame.
    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_page  <= i_req.page;
            r_hit   <= 1'b0;
            r_empty <= 1'b0;
        end else if ((r_state == S_SCAN) && r_chk_vld) begin
            if (rd_frame_valid && (rd_page == r_page) && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_chk_idx;
                r_hit_rank <= rd_rank;
            end
            if (!rd_frame_valid && !r_empty) begin
                r_empty     <= 1'b1;
                r_empty_idx <= r_chk_idx;
            end
            if ((r_chk_idx == IW'(0)) || (rd_rank > r_worst_rank)) begin
                r_worst_idx  <= r_chk_idx;
                r_worst_rank <= rd_rank;
            end
        end
    end

    // Latch the chosen frame for the recency sweep.
    always_ff @(posedge i_clk) begin
        if (r_state == S_PICK) begin
            r_sel_idx        <= pick_idx;
            r_sel_prev_valid <= pick_prev_valid;
            r_sel_rank       <= pick_rank;
            r_fault          <= pick_fault;
        end
    end

    // Valid bits and fault count; a new sequence clears both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_fault_cnt <= '0;
        end else if (req_xfer && i_req.first_of_sequence) begin
            r_valid     <= '0;
            r_fault_cnt <= '0;
        end else if (r_state == S_PICK) begin
            r_valid[pick_idx] <= 1'b1;
            if (pick_fault && !(&r_fault_cnt)) begin
                r_fault_cnt <= r_fault_cnt + FAULT_CNT_W'(1);
            end
        end
    end

    // Output register holds the result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_vld   <= 1'b1;
            r_out_fault <= r_fault;
            r_out_idx   <= FRAME_IDX_W'(r_sel_idx);
            r_out_cnt   <= r_fault_cnt;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // The frame table is written only during the recency sweep.
    a_wr_only_in_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr_en |-> (r_state == S_UPD))
        else $error("frame table written outside the update sweep");

    // The chosen frame is valid for the whole recency sweep.
    a_sel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |-> r_valid[r_sel_idx])
        else $error("chosen frame not marked valid");

    // A hit leaves the fault count unchanged.
    a_hit_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PICK && !pick_fault) |=> (r_fault_cnt == $past(r_fault_cnt)))
        else $error("fault count changed on a hit");

    // While a reference is in work the fault count never drops.
    a_cnt_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> (r_fault_cnt >= $past(r_fault_cnt)))
        else $error("fault count dropped inside a reference");

endmodule

@@ hdl/lru_page_replacement.sv @@
`timescale 1ns / 1ps

// LRU page replacement over FRAME_COUNT fully associative page frames. Each request
// transfer carries one page reference and returns one result: hit or fault, the frame
// used and the saturating fault count of the current sequence; first_of_sequence empties
// all frames and zeroes the count before the reference. The frame table (page and exact
// recency rank per frame) sits in a one-read, one-write memory with a registered read, and
// frame valid bits sit in flip-flops, so no clearing pass follows reset. A reference is
// handled one at a time in steps, where active is frames_in_use clamped to 1..FRAME_COUNT:
// one sweep of the memory read port over the active frames for the match and the
// replacement choice, a pick state to choose the frame, and one sweep over all frames to
// rewrite the recency ranks. The next request is taken while a finished result still
// waits in the output register. The user must write frames_in_use through i_cfg_we /
// i_cfg_wdata only while the block is idle; the block itself does not enforce this.
module lru_page_replacement
    import lrup_pkg::*;
#(
    parameter int FRAME_COUNT = 16,
    parameter int PAGE_BITS   = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lrup_req_if.sink         i_req,
    lrup_rsp_if.source       o_rsp
);

    localparam int IW    = $clog2(FRAME_COUNT);
    localparam int CNT_W = $clog2(FRAME_COUNT + 1);
    localparam int MW    = PAGE_BITS + IW;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0] r_frames_in_use;
    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] active;

    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    logic [MW-1:0] mem_rd_data;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    logic [MW-1:0] mem_wr_data;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET_VAL;
        end else if (i_cfg_we) begin
            r_frames_in_use <= i_cfg_wdata;
        end
    end

    // Active frame count: zero acts as one, values above the frame count are clamped.
    assign cfg_ext = CMP_W'(r_frames_in_use);

    always_comb begin
        if (cfg_ext == '0) begin
            active = CNT_W'(1);
        end else if (cfg_ext > CMP_W'(FRAME_COUNT)) begin
            active = CNT_W'(FRAME_COUNT);
        end else begin
            active = cfg_ext[CNT_W-1:0];
        end
    end

    lrup_ctrl #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_active      (active),
        .i_req         (i_req),
        .o_rsp         (o_rsp),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data)
    );

    lrup_frame_mem #(
        .DEPTH  (FRAME_COUNT),
        .DATA_W (MW)
    ) u_frame_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import lrup_pkg::*;

    localparam int FRAME_COUNT  = 16;
    localparam int PAGE_BITS    = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int END_SETTLE   = 40;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic                 first_of_sequence;
    } t_page_ref;

    typedef struct packed {
        logic                   fault;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic [FAULT_CNT_W-1:0] fault_count;
    } t_page_result;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    lrup_req_if #(.PAGE_BITS(PAGE_BITS)) req_bus ();
    lrup_rsp_if                          rsp_bus ();

    lru_page_replacement #(
        .FRAME_COUNT (FRAME_COUNT),
        .PAGE_BITS   (PAGE_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_bus),
        .o_rsp       (rsp_bus)
    );

    always #5 clk = ~clk;

    // Shadow copy of the frame table, the fault counter and the register.
    logic [PAGE_BITS-1:0]   shadow_page  [FRAME_COUNT];
    logic                   shadow_valid [FRAME_COUNT];
    logic [3:0]             shadow_rank  [FRAME_COUNT];
    logic [FAULT_CNT_W-1:0] shadow_faults;
    logic [CFG_W-1:0]       shadow_frames_in_use;

    t_page_ref    pending_refs[$];
    t_page_result expected_results[$];

    int          req_idle_pct;
    int          rsp_stall_pct;
    bit          hold_toggle;
    bit          hold_seen;
    int          hold_left;
    int          mismatch_count;
    int unsigned cycle_count;
    t_page_ref   offered;

    // Number of frames that take part for a given register value.
    function automatic int active_frames(input logic [CFG_W-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > FRAME_COUNT)
            return FRAME_COUNT;
        return int'(cfg);
    endfunction

    // Make frame f the most recent, shifting the younger valid frames down (all valid frames if f was not valid).
    function automatic void touch_frame(input int f, input bit was_valid);
        logic [3:0] old;
        old = shadow_rank[f];
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (i != f && shadow_valid[i] && (!was_valid || shadow_rank[i] < old))
                shadow_rank[i] = shadow_rank[i] + 1'b1;
        end
        shadow_rank[f]  = '0;
        shadow_valid[f] = 1'b1;
    endfunction

    // Apply one reference to the shadow table and return the result it should give.
    function automatic t_page_result predict_reference(input t_page_ref r);
        t_page_result res;
        int           active;
        int           f;
        bit           found;
        bit           empty;
        logic [3:0]   worst;
        found = 1'b0;
        empty = 1'b0;
        f     = 0;
        if (r.first_of_sequence) begin
            for (int i = 0; i < FRAME_COUNT; i++) begin
                shadow_valid[i] = 1'b0;
                shadow_page[i]  = '0;
                shadow_rank[i]  = '0;
            end
            shadow_faults = '0;
        end
        active = active_frames(shadow_frames_in_use);

        // Lowest-numbered active frame holding the page wins.
        for (int i = 0; i < active; i++) begin
            if (!found && shadow_valid[i] && shadow_page[i] == r.page) begin
                f     = i;
                found = 1'b1;
            end
        end

        if (found) begin
            touch_frame(f, 1'b1);
        end else begin
            for (int i = 0; i < active; i++) begin
                if (!empty && !shadow_valid[i]) begin
                    f     = i;
                    empty = 1'b1;
                end
            end
            // No empty frame: evict the oldest active frame.
            if (!empty) begin
                f     = 0;
                worst = shadow_rank[0];
                for (int i = 1; i < active; i++) begin
                    if (shadow_rank[i] > worst) begin
                        worst = shadow_rank[i];
                        f     = i;
                    end
                end
            end
            shadow_page[f] = r.page;
            touch_frame(f, !empty);
            if (shadow_faults != '1)
                shadow_faults = shadow_faults + 1'b1;
        end

        res.fault       = !found;
        res.frame_index = f[FRAME_IDX_W-1:0];
        res.fault_count = shadow_faults;
        return res;
    endfunction

    // Driver: offers queued references and predicts each one on its transfer.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            if (req_bus.valid && req_bus.ready)
                expected_results.push_back(predict_reference(offered));
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_refs.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
                    offered                   = pending_refs.pop_front();
                    req_bus.valid             <= 1'b1;
                    req_bus.page              <= offered.page;
                    req_bus.first_of_sequence <= offered.first_of_sequence;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: drives ready, holds off on request, and checks every result transfer.
    always @(posedge clk) begin : monitor
        t_page_result want;
        if (!rst_n) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= 0;
            hold_seen     <= hold_toggle;
        end else begin
            if (hold_toggle != hold_seen) begin
                hold_seen <= hold_toggle;
                hold_left <= HOLD_CYCLES;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
            rsp_bus.ready <= (hold_left == 0) && (hold_toggle == hold_seen) &&
                             ($urandom_range(99) >= rsp_stall_pct);

            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: fault=%0b frame=%0d count=%0d",
                             $time, rsp_bus.fault, rsp_bus.frame_index, rsp_bus.fault_count);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (rsp_bus.fault !== want.fault) begin
                        $display("%0t: fault expected %0b actual %0b",
                                 $time, want.fault, rsp_bus.fault);
                        mismatch_count++;
                    end
                    if (rsp_bus.frame_index !== want.frame_index) begin
                        $display("%0t: frame_index expected %0d actual %0d",
                                 $time, want.frame_index, rsp_bus.frame_index);
                        mismatch_count++;
                    end
                    if (rsp_bus.fault_count !== want.fault_count) begin
                        $display("%0t: fault_count expected %0d actual %0d",
                                 $time, want.fault_count, rsp_bus.fault_count);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic add_ref(input logic [PAGE_BITS-1:0] page, input logic first);
        t_page_ref r;
        r.page              = page;
        r.first_of_sequence = first;
        pending_refs.push_back(r);
    endtask

    // Wait until every reference has been sent and every result has arrived.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_refs.size() != 0 || req_bus.valid || expected_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_frames_in_use(input logic [CFG_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_frames_in_use = value;
        @(negedge clk);
    endtask

    // Random references: mostly sequences over a small page pool sized to the
    // active frames, with some wide-range noise and stray sequence restarts.
    task automatic add_random_refs(input int count, input int active, input bit fresh);
        int                   left;
        int                   seq_len;
        int                   pool;
        logic [PAGE_BITS-1:0] base;
        bit                   first_pending;
        t_page_ref            r;
        left          = count;
        first_pending = fresh;
        while (left > 0) begin
            seq_len = $urandom_range(4, 60);
            pool    = active + $urandom_range(0, 3);
            base    = PAGE_BITS'($urandom);
            for (int k = 0; k < seq_len && left > 0; k++) begin
                r.first_of_sequence = first_pending;
                first_pending       = 1'b0;
                if ($urandom_range(99) < 8)
                    r.page = PAGE_BITS'($urandom);
                else
                    r.page = base + PAGE_BITS'($urandom_range(0, pool - 1));
                if ($urandom_range(99) < 2)
                    r.first_of_sequence = 1'b1;
                pending_refs.push_back(r);
                left--;
            end
            first_pending = ($urandom_range(99) < 85);
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] cfg, input int idle_pct,
                             input int stall_pct, input int count, input bit pressure);
        write_frames_in_use(cfg);
        req_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
        if (pressure) begin
            // Long receiver hold-off while the sender keeps offering, then a full drain.
            hold_toggle = ~hold_toggle;
            add_random_refs(count / 2, active_frames(cfg), 1'b1);
            wait_idle();
            add_random_refs(count - count / 2, active_frames(cfg), 1'b0);
        end else begin
            add_random_refs(count, active_frames(cfg), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_wdata                 = '0;
        req_bus.valid             = 1'b0;
        req_bus.page              = '0;
        req_bus.first_of_sequence = 1'b0;
        rsp_bus.ready             = 1'b0;
        req_idle_pct              = 0;
        rsp_stall_pct             = 0;
        hold_toggle               = 1'b0;
        mismatch_count            = 0;
        cycle_count               = 0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_page[i]  = '0;
            shadow_rank[i]  = '0;
        end
        shadow_faults        = '0;
        shadow_frames_in_use = CFG_RESET_VAL;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: first sequence straight from reset, page extremes, hit and restart.
        add_ref(16'h0000, 1'b0);
        add_ref(16'hFFFF, 1'b0);
        add_ref(16'h0000, 1'b0);
        add_ref(16'hAAAA, 1'b0);
        add_ref(16'h5555, 1'b0);
        add_ref(16'h5555, 1'b1);

        // A single frame: every miss evicts frame 0.
        write_frames_in_use(5'd1);
        add_ref(16'h0007, 1'b0);
        add_ref(16'h0007, 1'b0);
        add_ref(16'h0009, 1'b0);

        // Zero behaves as one frame.
        write_frames_in_use(5'd0);
        add_ref(16'h0005, 1'b0);
        add_ref(16'h0005, 1'b0);

        // Shrinking leaves a stale copy in frame 1; after growing, frame 0 must hit.
        write_frames_in_use(5'd2);
        add_ref(16'h00A0, 1'b1);
        add_ref(16'h00B0, 1'b0);
        write_frames_in_use(5'd1);
        add_ref(16'h00B0, 1'b0);
        write_frames_in_use(5'd2);
        add_ref(16'h00B0, 1'b0);
        add_ref(16'h00C0, 1'b0);

        // Oversized register value behaves as the full frame count.
        write_frames_in_use(5'd31);
        add_ref(16'h00C0, 1'b0);
        add_ref(16'h1234, 1'b0);

        // Random phases over several frame counts and idling patterns.
        run_phase(5'd16,  0,  0, 200, 1'b0);
        run_phase(5'd4,  70,  0, 150, 1'b0);
        run_phase(5'd1,   0, 70, 100, 1'b0);
        run_phase(5'd9,  26, 26, 150, 1'b0);
        run_phase(5'd31,  0,  0, 150, 1'b1);
        run_phase(5'd3,  26, 26, 100, 1'b0);
        run_phase(5'd16,  0, 70, 200, 1'b0);
        run_phase(5'd0,  70,  0, 100, 1'b0);
        run_phase(5'd12,  0,  0, 150, 1'b0);
        run_phase(5'd7,  26, 26, 150, 1'b0);

        wait_idle();
        repeat (END_SETTLE) @(negedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
